// ===== hdl/fdlh_pkg.sv =====
// Shared widths, register indexes, region codes and lane bundles for the fan duty block.
`default_nettype none
package fdlh_pkg;

    localparam int TEMP_W     = 8;
    localparam int DUTY_W     = 8;
    localparam int REGION_W   = 3;
    localparam int HYST_W     = 6;
    localparam int SHIFT_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int X_W      = TEMP_W + 2;
    localparam int SPAN_W   = DUTY_W + 1;
    localparam int MAG_W    = X_W - 1;
    localparam int PROD_W   = MAG_W + DUTY_W;
    localparam int QUO_W    = DUTY_W + 1;
    localparam int BOUND_W  = DUTY_W + 3;
    localparam int MUL_STEPS = DUTY_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W    = 4;

    localparam int unsigned FULL_DUTY_DEF = 255;

    localparam logic [TEMP_W-1:0]  LOW_TEMP_RST   = 8'd39;
    localparam logic [TEMP_W-1:0]  HIGH_TEMP_RST  = 8'd52;
    localparam logic [DUTY_W-1:0]  LOW_DUTY_RST   = 8'd128;
    localparam logic [DUTY_W-1:0]  HIGH_DUTY_RST  = 8'd255;
    localparam logic [HYST_W-1:0]  HYST_RST       = 6'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_RST      = 7'd0;
    localparam logic [DUTY_W-1:0]  START_DUTY_RST = 8'd128;
    localparam logic [DUTY_W-1:0]  FLOOR_DUTY_RST = 8'd0;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TEMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_DUTY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_DUTY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HYST       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SHIFT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_DUTY = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DUTY = 3'd7;

    localparam logic [REGION_W-1:0] REGION_FIRST   = 3'd0;
    localparam logic [REGION_W-1:0] REGION_FULL    = 3'd1;
    localparam logic [REGION_W-1:0] REGION_FLOOR   = 3'd2;
    localparam logic [REGION_W-1:0] REGION_TRACKED = 3'd3;
    localparam logic [REGION_W-1:0] REGION_DIV_ERR = 3'd4;

    typedef struct packed {
        logic              start;
        logic [X_W-1:0]    x;
        logic [SPAN_W-1:0] span;
        logic [DUTY_W-1:0] divisor;
        logic [DUTY_W-1:0] base;
    } lane_req_t;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] bound;
    } lane_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/fdlh_bound.sv =====
// One bound lane: bit-serial multiply, bit-serial divide, offset and saturate.
`default_nettype none
module fdlh_bound (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fdlh_pkg::lane_req_t req,
    output fdlh_pkg::lane_rsp_t    rsp
);
    import fdlh_pkg::*;

    typedef enum logic [4:0] {
        LN_IDLE = 5'b00001,
        LN_MUL  = 5'b00010,
        LN_CHK  = 5'b00100,
        LN_DIV  = 5'b01000,
        LN_FIN  = 5'b10000
    } lane_state_t;

    lane_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [DUTY_W-1:0] mplier_reg, mplier_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [DUTY_W-1:0] div_reg, div_next;
    logic [DUTY_W-1:0] base_reg, base_next;
    logic              sat_reg, sat_next;
    logic [DUTY_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  dvd_reg, dvd_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DUTY_W-1:0] bound_reg, bound_next;
    logic              done_reg, done_next;

    logic [X_W-1:0]     x_neg;
    logic [SPAN_W-1:0]  span_neg;
    logic [MAG_W-1:0]   x_mag;
    logic [DUTY_W-1:0]  span_mag;
    logic [QUO_W-1:0]   trial;
    logic               trial_ge;
    logic [BOUND_W-1:0] q_ext;
    logic [BOUND_W-1:0] val;

    assign x_neg    = -req.x;
    assign span_neg = -req.span;
    assign x_mag    = req.x[X_W-1] ? x_neg[MAG_W-1:0] : req.x[MAG_W-1:0];
    assign span_mag = req.span[SPAN_W-1] ? span_neg[DUTY_W-1:0] : req.span[DUTY_W-1:0];

    assign trial    = {rem_reg, dvd_reg[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, div_reg};

    assign q_ext = {{(BOUND_W-QUO_W){1'b0}}, quo_reg};
    assign val   = {{(BOUND_W-DUTY_W){1'b0}}, base_reg} + (neg_reg ? -q_ext : q_ext);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        div_next    = div_reg;
        base_next   = base_reg;
        sat_next    = sat_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        bound_next  = bound_reg;
        done_next   = 1'b0;
        case (state_reg)
            LN_IDLE: begin
                if (req.start) begin
                    mcand_next  = {{(PROD_W-MAG_W){1'b0}}, x_mag};
                    mplier_next = span_mag;
                    acc_next    = '0;
                    neg_next    = req.x[X_W-1] ^ req.span[SPAN_W-1];
                    div_next    = req.divisor;
                    base_next   = req.base;
                    cnt_next    = '0;
                    state_next  = LN_MUL;
                end
            end
            LN_MUL: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = LN_CHK;
                end
            end
            LN_CHK: begin
                // quotient of 512 or more saturates either way
                sat_next   = acc_reg[PROD_W-1:QUO_W] >= div_reg;
                rem_next   = acc_reg[PROD_W-1:QUO_W];
                dvd_next   = acc_reg[QUO_W-1:0];
                quo_next   = '0;
                state_next = LN_DIV;
            end
            LN_DIV: begin
                rem_next = trial_ge ? DUTY_W'(trial - {1'b0, div_reg}) : trial[DUTY_W-1:0];
                dvd_next = dvd_reg << 1;
                quo_next = {quo_reg[QUO_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = LN_FIN;
                end
            end
            LN_FIN: begin
                if (sat_reg) begin
                    bound_next = neg_reg ? '0 : '1;
                end else if (val[BOUND_W-1]) begin
                    bound_next = '0;
                end else if (val[BOUND_W-2:DUTY_W] != '0) begin
                    bound_next = '1;
                end else begin
                    bound_next = val[DUTY_W-1:0];
                end
                done_next  = 1'b1;
                state_next = LN_IDLE;
            end
            default: begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        div_reg    <= div_next;
        base_reg   <= base_next;
        sat_reg    <= sat_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        bound_reg  <= bound_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.bound = bound_reg;

endmodule
`default_nettype wire

// ===== hdl/fan_duty_linear_hysteresis.sv =====
// Top level: fan duty from a linear curve with hysteresis, two bit-serial bound lanes.
//
//  channel  ports          payload
//  -------  -------------  ---------------------------------------------
//  input    s_tvalid/ready s_tdata[7:0] temperature
//  result   m_tvalid/ready m_tdata[7:0] duty, m_tuser[2:0] region
//  config   cfg_wr_en      cfg_wr_index[2:0], cfg_wr_data[7:0]
//
// Each lane loads a sample on accept, then runs 8 multiply steps, a check,
// 9 divide steps and a finish; the top then decides and emits the result.
// Reset is synchronous and active low; it restores the register defaults
// and clears the sample history. A result beat waits in the output
// register; the next sample is taken meanwhile and its result stalls
// until that beat is gone.
`default_nettype none
module fan_duty_linear_hysteresis #(
    parameter int unsigned FULL_DUTY = fdlh_pkg::FULL_DUTY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fdlh_pkg::TEMP_W-1:0]     s_tdata,      // [7:0] temperature
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fdlh_pkg::DUTY_W-1:0]          m_tdata,      // [7:0] duty
    output logic [fdlh_pkg::REGION_W-1:0]        m_tuser,      // [2:0] region
    input  wire logic                            cfg_wr_en,
    input  wire logic [fdlh_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [fdlh_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import fdlh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_EMIT = 3'b100
    } top_state_t;

    top_state_t         state_reg, state_next;

    logic [TEMP_W-1:0]  low_temp_reg, high_temp_reg;
    logic [DUTY_W-1:0]  low_duty_reg, high_duty_reg, start_duty_reg, floor_duty_reg;
    logic [HYST_W-1:0]  hyst_reg;
    logic [SHIFT_W-1:0] shift_reg;

    logic               seen_reg, seen_next;
    logic [TEMP_W-1:0]  prev_temp_reg, prev_temp_next;
    logic [DUTY_W-1:0]  prev_duty_reg, prev_duty_next;
    logic [TEMP_W-1:0]  t_reg, t_next;
    logic [DUTY_W-1:0]  ub_reg, ub_next, lb_reg, lb_next;
    logic               m_valid_reg, m_valid_next;
    logic [DUTY_W-1:0]  m_duty_reg, m_duty_next;
    logic [REGION_W-1:0] m_region_reg, m_region_next;

    lane_req_t          ub_req, lb_req;
    lane_rsp_t          ub_rsp, lb_rsp;

    logic               accept;
    logic               out_free;
    logic [X_W-1:0]     shift_ext;
    logic [X_W-1:0]     x_ub;
    logic [X_W-1:0]     div_val;
    logic               div_ok;
    logic [X_W-1:0]     full_lim, floor_lim;
    logic [X_W-1:0]     t_ext;
    logic               full_hit, floor_hit;
    logic [DUTY_W-1:0]  pick, clamped, first_duty;
    logic [DUTY_W-1:0]  res_duty, res_prev;
    logic [REGION_W-1:0] res_region;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign shift_ext = {{(X_W-SHIFT_W){shift_reg[SHIFT_W-1]}}, shift_reg};

    assign x_ub    = {2'b00, s_tdata} - {2'b00, low_temp_reg} + shift_ext;
    assign div_val = {2'b00, high_temp_reg} - {2'b00, low_temp_reg}
                   - {{(X_W-HYST_W){1'b0}}, hyst_reg};
    assign div_ok  = !div_val[X_W-1] && (div_val != '0);

    always_comb begin
        ub_req.start   = accept;
        ub_req.x       = x_ub;
        ub_req.span    = {1'b0, high_duty_reg} - {1'b0, low_duty_reg};
        ub_req.divisor = div_val[DUTY_W-1:0];
        ub_req.base    = low_duty_reg;
        lb_req         = ub_req;
        lb_req.x       = x_ub - {{(X_W-HYST_W){1'b0}}, hyst_reg};
    end

    fdlh_bound u_ub (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ub_req),
        .rsp     (ub_rsp)
    );

    fdlh_bound u_lb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lb_req),
        .rsp     (lb_rsp)
    );

    assign t_ext     = {2'b00, t_reg};
    assign full_lim  = {2'b00, high_temp_reg} - shift_ext;
    assign floor_lim = {2'b00, low_temp_reg} - shift_ext;
    assign full_hit  = $signed(t_ext) >= $signed(full_lim);
    assign floor_hit = $signed(t_ext) < $signed(floor_lim);

    always_comb begin
        if (t_reg > prev_temp_reg) begin
            pick = (lb_reg < prev_duty_reg) ? prev_duty_reg : lb_reg;
        end else if (t_reg < prev_temp_reg) begin
            pick = (ub_reg > prev_duty_reg) ? prev_duty_reg : ub_reg;
        end else begin
            pick = prev_duty_reg;
        end
        if (pick > high_duty_reg) begin
            clamped = high_duty_reg;
        end else if (pick < low_duty_reg) begin
            clamped = low_duty_reg;
        end else begin
            clamped = pick;
        end
        first_duty = (lb_reg > start_duty_reg) ? lb_reg : start_duty_reg;

        if (!div_ok) begin
            res_duty   = DUTY_W'(FULL_DUTY);
            res_prev   = DUTY_W'(FULL_DUTY);
            res_region = REGION_DIV_ERR;
        end else if (!seen_reg) begin
            res_duty   = first_duty;
            res_prev   = lb_reg;
            res_region = REGION_FIRST;
        end else if (full_hit) begin
            res_duty   = DUTY_W'(FULL_DUTY);
            res_prev   = DUTY_W'(FULL_DUTY);
            res_region = REGION_FULL;
        end else if (floor_hit) begin
            res_duty   = floor_duty_reg;
            res_prev   = floor_duty_reg;
            res_region = REGION_FLOOR;
        end else begin
            res_duty   = clamped;
            res_prev   = clamped;
            res_region = REGION_TRACKED;
        end
    end

    always_comb begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        prev_temp_next = prev_temp_reg;
        prev_duty_next = prev_duty_reg;
        t_next         = t_reg;
        ub_next        = ub_reg;
        lb_next        = lb_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_duty_next    = m_duty_reg;
        m_region_next  = m_region_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    t_next     = s_tdata;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (ub_rsp.done && lb_rsp.done) begin
                    ub_next    = ub_rsp.bound;
                    lb_next    = lb_rsp.bound;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_duty_next    = res_duty;
                    m_region_next  = res_region;
                    seen_next      = 1'b1;
                    prev_temp_next = t_reg;
                    prev_duty_next = res_prev;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seen_reg       <= 1'b0;
            prev_temp_reg  <= '0;
            prev_duty_reg  <= '0;
            m_valid_reg    <= 1'b0;
            low_temp_reg   <= LOW_TEMP_RST;
            high_temp_reg  <= HIGH_TEMP_RST;
            low_duty_reg   <= LOW_DUTY_RST;
            high_duty_reg  <= HIGH_DUTY_RST;
            hyst_reg       <= HYST_RST;
            shift_reg      <= SHIFT_RST;
            start_duty_reg <= START_DUTY_RST;
            floor_duty_reg <= FLOOR_DUTY_RST;
        end else begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            prev_temp_reg <= prev_temp_next;
            prev_duty_reg <= prev_duty_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_LOW_TEMP:   low_temp_reg   <= cfg_wr_data;
                    REG_HIGH_TEMP:  high_temp_reg  <= cfg_wr_data;
                    REG_LOW_DUTY:   low_duty_reg   <= cfg_wr_data;
                    REG_HIGH_DUTY:  high_duty_reg  <= cfg_wr_data;
                    REG_HYST:       hyst_reg       <= cfg_wr_data[HYST_W-1:0];
                    REG_TEMP_SHIFT: shift_reg      <= cfg_wr_data[SHIFT_W-1:0];
                    REG_START_DUTY: start_duty_reg <= cfg_wr_data;
                    REG_FLOOR_DUTY: floor_duty_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
        t_reg        <= t_next;
        ub_reg       <= ub_next;
        lb_reg       <= lb_next;
        m_duty_reg   <= m_duty_next;
        m_region_reg <= m_region_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_duty_reg;
    assign m_tuser  = m_region_reg;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for the fan duty curve block: directed table, then randomized phases.
`timescale 1ns / 1ps
module tb_top;
    import fdlh_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned SETTLE         = 30;
    localparam int unsigned TAIL           = 40;
    localparam int unsigned PHASES         = 14;
    localparam int unsigned PHASE_ITEMS    = 118;
    localparam logic [DUTY_W-1:0] FULL_LVL = DUTY_W'(FULL_DUTY_DEF);

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [DUTY_W-1:0]   duty;
    } duty_beat_t;

    typedef struct packed {
        logic pinned;
        duty_beat_t val;
    } pinned_beat_t;

    typedef struct packed {
        logic [7:0] lo_temp;
        logic [7:0] hi_temp;
        logic [7:0] lo_duty;
        logic [7:0] hi_duty;
        logic [7:0] hyst;
        logic [7:0] shift;
        logic [7:0] start_duty;
        logic [7:0] floor_duty;
    } fan_cfg_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  pinned;
        duty_beat_t            val;
    } step_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TEMP_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DUTY_W-1:0] m_tdata;
    logic [REGION_W-1:0] m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    fan_cfg_t cfg_now = '{lo_temp: LOW_TEMP_RST, hi_temp: HIGH_TEMP_RST,
                          lo_duty: LOW_DUTY_RST, hi_duty: HIGH_DUTY_RST,
                          hyst: 8'(HYST_RST), shift: 8'(SHIFT_RST),
                          start_duty: START_DUTY_RST, floor_duty: FLOOR_DUTY_RST};
    logic have_sample = 1'b0;
    logic [TEMP_W-1:0] hist_temp = '0;
    logic [DUTY_W-1:0] last_duty = '0;

    duty_beat_t duty_q[$];
    pinned_beat_t pin_q[$];
    int unsigned fail_cnt = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned quiet_cycles = 0;
    logic hold_on = 1'b0;
    event hold_go;

    duty_beat_t want;
    duty_beat_t pred;
    pinned_beat_t pin;

    fan_duty_linear_hysteresis #(
        .FULL_DUTY(FULL_DUTY_DEF)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int clamp_byte(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic duty_beat_t next_fan_duty(input logic [TEMP_W-1:0] temp);
        duty_beat_t r;
        int t, offs, lt, ht, ld, hd, hy, dv, span, ub, lb, d;
        t = temp;
        lt = cfg_now.lo_temp;
        ht = cfg_now.hi_temp;
        ld = cfg_now.lo_duty;
        hd = cfg_now.hi_duty;
        hy = cfg_now.hyst[HYST_W-1:0];
        offs = $signed(cfg_now.shift[SHIFT_W-1:0]);
        dv = ht - lt - hy;
        span = hd - ld;
        if (dv <= 0) begin
            r.duty = FULL_LVL;
            r.region = REGION_DIV_ERR;
            have_sample = 1'b1;
            last_duty = FULL_LVL;
        end else begin
            ub = clamp_byte((t - lt + offs) * span / dv + ld);
            lb = clamp_byte((t - lt + offs - hy) * span / dv + ld);
            if (!have_sample) begin
                d = (lb > int'(cfg_now.start_duty)) ? lb : int'(cfg_now.start_duty);
                r.duty = DUTY_W'(d);
                r.region = REGION_FIRST;
                have_sample = 1'b1;
                last_duty = DUTY_W'(lb);
            end else begin
                if (t >= ht - offs) begin
                    d = FULL_LVL;
                    r.region = REGION_FULL;
                end else if (t < lt - offs) begin
                    d = cfg_now.floor_duty;
                    r.region = REGION_FLOOR;
                end else begin
                    if (t > int'(hist_temp))
                        d = (lb < int'(last_duty)) ? int'(last_duty) : lb;
                    else if (t < int'(hist_temp))
                        d = (ub > int'(last_duty)) ? int'(last_duty) : ub;
                    else
                        d = last_duty;
                    if (d > hd) d = hd;
                    else if (d < ld) d = ld;
                    r.region = REGION_TRACKED;
                end
                r.duty = DUTY_W'(d);
                last_duty = r.duty;
            end
        end
        hist_temp = temp;
        return r;
    endfunction

    // Walk near the ramp most of the time so the tracking paths get exercised.
    function automatic logic [TEMP_W-1:0] pick_temp(input logic [TEMP_W-1:0] prev);
        int p, offs, lo, hi, r, t;
        p = prev;
        offs = $signed(cfg_now.shift[SHIFT_W-1:0]);
        lo = int'(cfg_now.lo_temp) - offs;
        hi = int'(cfg_now.hi_temp) - offs;
        r = $urandom_range(99);
        if (r < 60) begin
            t = p + int'($urandom_range(6)) - 3;
            if ((t < lo || t > hi) && lo < hi && hi >= 0 && lo <= 255)
                t = lo + int'($urandom_range(hi - lo));
        end else if (r < 85) begin
            t = $urandom_range(255);
        end else if (r < 93) begin
            t = lo + int'($urandom_range(4)) - 2;
        end else begin
            t = hi + int'($urandom_range(4)) - 2;
        end
        if (t < 0) t = 0;
        else if (t > 255) t = 255;
        return TEMP_W'(t);
    endfunction

    function automatic fan_cfg_t rand_cfg();
        fan_cfg_t c;
        int lt, ht, hy, sh;
        logic [7:0] tmp;
        hy = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(8);
        lt = $urandom_range(200);
        ht = lt + hy + 1 + int'($urandom_range(40));
        if (ht > 255) ht = 255;
        sh = ($urandom_range(3) == 0) ? int'($urandom_range(127)) : int'($urandom_range(16)) - 8;
        c.lo_temp = 8'(lt);
        c.hi_temp = 8'(ht);
        c.lo_duty = 8'($urandom_range(255));
        c.hi_duty = 8'($urandom_range(255));
        if ($urandom_range(3) != 0 && c.lo_duty > c.hi_duty) begin
            tmp = c.lo_duty;
            c.lo_duty = c.hi_duty;
            c.hi_duty = tmp;
        end
        c.hyst = {2'($urandom_range(3)), 6'(hy)};
        c.shift = {1'($urandom_range(1)), 7'(sh)};
        c.start_duty = 8'($urandom_range(255));
        c.floor_duty = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic step_row_t row_temp(input logic [TEMP_W-1:0] t);
        return '{is_cfg: 1'b0, idx: '0, data: t, pinned: 1'b0, val: '0};
    endfunction

    function automatic step_row_t row_pin(input logic [TEMP_W-1:0] t,
                                          input logic [DUTY_W-1:0] duty,
                                          input logic [REGION_W-1:0] region);
        return '{is_cfg: 1'b0, idx: '0, data: t, pinned: 1'b1,
                 val: '{region: region, duty: duty}};
    endfunction

    function automatic step_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        return '{is_cfg: 1'b1, idx: idx, data: data, pinned: 1'b0, val: '0};
    endfunction

    task automatic send_temp(input logic [TEMP_W-1:0] t);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (duty_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LOW_TEMP:   cfg_now.lo_temp = data;
            REG_HIGH_TEMP:  cfg_now.hi_temp = data;
            REG_LOW_DUTY:   cfg_now.lo_duty = data;
            REG_HIGH_DUTY:  cfg_now.hi_duty = data;
            REG_HYST:       cfg_now.hyst = data;
            REG_TEMP_SHIFT: cfg_now.shift = data;
            REG_START_DUTY: cfg_now.start_duty = data;
            REG_FLOOR_DUTY: cfg_now.floor_duty = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_config(input fan_cfg_t c);
        write_reg(REG_LOW_TEMP, c.lo_temp);
        write_reg(REG_HIGH_TEMP, c.hi_temp);
        write_reg(REG_LOW_DUTY, c.lo_duty);
        write_reg(REG_HIGH_DUTY, c.hi_duty);
        write_reg(REG_HYST, c.hyst);
        write_reg(REG_TEMP_SHIFT, c.shift);
        write_reg(REG_START_DUTY, c.start_duty);
        write_reg(REG_FLOOR_DUTY, c.floor_duty);
    endtask

    always @(posedge aclk)
        m_tready <= !hold_on && ($urandom_range(99) >= snk_stall_pct);

    // Hold off the result side long enough for the block to back up.
    always begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_on <= 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (duty_q.size() == 0) begin
                    $error("result beat with nothing expected: duty %0d region %0d",
                           m_tdata, m_tuser);
                    fail_cnt++;
                end else begin
                    want = duty_q.pop_front();
                    if (m_tdata !== want.duty) begin
                        $error("duty mismatch: expected %0d, actual %0d", want.duty, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tuser !== want.region) begin
                        $error("region mismatch: expected %0d, actual %0d",
                               want.region, m_tuser);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pred = next_fan_duty(s_tdata);
                if (pin_q.size() != 0) begin
                    pin = pin_q.pop_front();
                    if (pin.pinned) pred = pin.val;
                end
                duty_q.push_back(pred);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        step_row_t dir_tab [28];
        fan_cfg_t pc;
        logic [TEMP_W-1:0] walk_t;
        dir_tab = '{
            row_pin(8'd0, 8'd128, REGION_FIRST),
            row_pin(8'd255, FULL_LVL, REGION_FULL),
            row_pin(8'd0, 8'd0, REGION_FLOOR),
            row_temp(8'd45),
            row_temp(8'd48),
            row_temp(8'd48),
            row_temp(8'd41),
            row_temp(8'd51),
            row_pin(8'd52, FULL_LVL, REGION_FULL),
            row_temp(8'd39),
            row_pin(8'd38, 8'd0, REGION_FLOOR),
            row_pin(8'd170, FULL_LVL, REGION_FULL),
            row_pin(8'd85, FULL_LVL, REGION_FULL),
            row_cfg(REG_HIGH_TEMP, 8'd42),
            row_pin(8'd100, FULL_LVL, REGION_DIV_ERR),
            row_pin(8'd0, FULL_LVL, REGION_DIV_ERR),
            row_cfg(REG_HIGH_TEMP, 8'd52),
            row_cfg(REG_TEMP_SHIFT, 8'h40),
            row_temp(8'd110),
            row_pin(8'd116, FULL_LVL, REGION_FULL),
            row_pin(8'd102, 8'd0, REGION_FLOOR),
            row_cfg(REG_LOW_DUTY, 8'd255),
            row_cfg(REG_HIGH_DUTY, 8'd0),
            row_temp(8'd105),
            row_temp(8'd112),
            row_temp(8'd108),
            row_cfg(REG_TEMP_SHIFT, 8'h3F),
            row_pin(8'd0, FULL_LVL, REGION_FULL)
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                drain_results();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                pin_q.push_back(pinned_beat_t'{pinned: dir_tab[i].pinned,
                                               val: dir_tab[i].val});
                send_temp(dir_tab[i].data);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: pc = '{lo_temp: 8'd0, hi_temp: 8'd255, lo_duty: 8'd0, hi_duty: 8'd255,
                          hyst: 8'hC0, shift: 8'h80, start_duty: 8'd255, floor_duty: 8'd255};
                1: pc = '{lo_temp: 8'd0, hi_temp: 8'd255, lo_duty: 8'd255, hi_duty: 8'd0,
                          hyst: 8'h3F, shift: 8'h40, start_duty: 8'd0, floor_duty: 8'd0};
                2: pc = '{lo_temp: 8'd100, hi_temp: 8'd180, lo_duty: 8'd128, hi_duty: 8'd255,
                          hyst: 8'h05, shift: 8'h3F, start_duty: 8'd0, floor_duty: 8'h5A};
                3: pc = '{lo_temp: 8'd255, hi_temp: 8'd0, lo_duty: 8'd10, hi_duty: 8'd200,
                          hyst: 8'h00, shift: 8'h00, start_duty: 8'd7, floor_duty: 8'd3};
                default: pc = rand_cfg();
            endcase
            apply_config(pc);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 84; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 84; end
                default: begin src_idle_pct = 7; snk_stall_pct = 7; end
            endcase
            if (p == 4) -> hold_go;
            walk_t = cfg_now.lo_temp;
            repeat (PHASE_ITEMS) begin
                walk_t = pick_temp(walk_t);
                send_temp(walk_t);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (duty_q.size() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
        if (fail_cnt == 0 && duty_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
